// ===== rtl/hc_pkg.sv =====
// ----------------------------------------------------------------------------
// hc_pkg
// Shared types, constants and mod 26 helpers for the 2x2 hill cipher.
// ----------------------------------------------------------------------------
package hc_pkg;

  localparam int LETTER_W   = 5;
  localparam int CFG_ADDR_W = 3;

  localparam logic [LETTER_W-1:0] MOD_LETTERS = 5'd26;
  localparam logic [LETTER_W-1:0] PAD_LETTER  = 5'd23;

  // configuration register indexes
  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_KEY_A = 3'd0,
    REG_KEY_B = 3'd1,
    REG_KEY_C = 3'd2,
    REG_KEY_D = 3'd3,
    REG_MODE  = 3'd4
  } cfg_reg_e;

  // active cipher matrix as seen by the pair multiplier
  typedef struct packed {
    logic [LETTER_W-1:0] m00;
    logic [LETTER_W-1:0] m01;
    logic [LETTER_W-1:0] m10;
    logic [LETTER_W-1:0] m11;
    logic                key_error;
  } key_mat_t;

  // 0..31 folded into 0..25
  function automatic logic [LETTER_W-1:0] red26(input logic [LETTER_W-1:0] x);
    logic [LETTER_W-1:0] r;
    r = (x >= MOD_LETTERS) ? x - MOD_LETTERS : x;
    return r;
  endfunction

  // 0..2047 mod 26 by folding: 64 = 12 and 32 = 6 (mod 26), then a few subtracts
  function automatic logic [LETTER_W-1:0] mod26(input logic [10:0] x);
    logic [8:0] y;
    logic [6:0] z;
    y = 9'({x[10:6], 3'b000}) + 9'({x[10:6], 2'b00}) + 9'(x[5:0]);
    z = 7'({y[8:5], 2'b00}) + 7'({y[8:5], 1'b0}) + 7'(y[4:0]);
    if (z >= 7'd104) begin
      z = z - 7'd104;
    end else if (z >= 7'd78) begin
      z = z - 7'd78;
    end else if (z >= 7'd52) begin
      z = z - 7'd52;
    end else if (z >= 7'd26) begin
      z = z - 7'd26;
    end
    return z[LETTER_W-1:0];
  endfunction

  // multiplicative inverse mod 26, zero when none exists
  function automatic logic [LETTER_W-1:0] inv26(input logic [LETTER_W-1:0] x);
    logic [LETTER_W-1:0] r;
    case (x)
      5'd1:    r = 5'd1;
      5'd3:    r = 5'd9;
      5'd5:    r = 5'd21;
      5'd7:    r = 5'd15;
      5'd9:    r = 5'd3;
      5'd11:   r = 5'd19;
      5'd15:   r = 5'd7;
      5'd17:   r = 5'd23;
      5'd19:   r = 5'd11;
      5'd21:   r = 5'd5;
      5'd23:   r = 5'd17;
      5'd25:   r = 5'd25;
      default: r = 5'd0;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/hc_key_unit.sv =====
// ----------------------------------------------------------------------------
// hc_key_unit
// Key and mode registers plus a two-stage pipeline that derives the active
// matrix (key or inverse key) and the key error flag.
// ----------------------------------------------------------------------------
module hc_key_unit import hc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [LETTER_W-1:0]   cfg_wdata,
  output key_mat_t              mat,
  output logic                  settle
);

  logic [LETTER_W-1:0] key_a, key_b, key_c, key_d;
  logic                mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_a <= 5'd1;
      key_b <= 5'd0;
      key_c <= 5'd0;
      key_d <= 5'd1;
      mode  <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_KEY_A: key_a <= cfg_wdata;
        REG_KEY_B: key_b <= cfg_wdata;
        REG_KEY_C: key_c <= cfg_wdata;
        REG_KEY_D: key_d <= cfg_wdata;
        REG_MODE:  mode  <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // input hold-off flag: set in reset and after any write while the matrix pipeline refills
  always_ff @(posedge clk) begin
    if (rst) begin
      settle <= 1'b1;
    end else begin
      settle <= cfg_we;
    end
  end

  // stage 1: reduced key, determinant and its inverse
  logic [LETTER_W-1:0] ra, rb, rc, rd, ad, bc, det, inv_next;
  logic [5:0]          det_raw;
  logic [LETTER_W-1:0] s1_a, s1_b, s1_c, s1_d, s1_inv;
  logic                s1_mode;

  always_comb begin
    ra       = red26(key_a);
    rb       = red26(key_b);
    rc       = red26(key_c);
    rd       = red26(key_d);
    ad       = mod26(11'(10'(ra) * 10'(rd)));
    bc       = mod26(11'(10'(rb) * 10'(rc)));
    det_raw  = 6'(ad) + 6'(MOD_LETTERS) - 6'(bc);
    det      = (det_raw >= 6'(MOD_LETTERS)) ? 5'(det_raw - 6'(MOD_LETTERS))
                                            : det_raw[LETTER_W-1:0];
    inv_next = inv26(det);
  end

  always_ff @(posedge clk) begin
    s1_a    <= ra;
    s1_b    <= rb;
    s1_c    <= rc;
    s1_d    <= rd;
    s1_inv  <= inv_next;
    s1_mode <= mode;
  end

  // stage 2: select key or inverse key
  key_mat_t mat_next;

  always_comb begin
    mat_next = '0;
    if (s1_inv == '0) begin
      mat_next.key_error = 1'b1;
    end else if (s1_mode) begin
      mat_next.m00 = mod26(11'(10'(s1_d) * 10'(s1_inv)));
      mat_next.m01 = mod26(11'(10'(MOD_LETTERS - s1_b) * 10'(s1_inv)));
      mat_next.m10 = mod26(11'(10'(MOD_LETTERS - s1_c) * 10'(s1_inv)));
      mat_next.m11 = mod26(11'(10'(s1_a) * 10'(s1_inv)));
    end else begin
      mat_next.m00 = s1_a;
      mat_next.m01 = s1_b;
      mat_next.m10 = s1_c;
      mat_next.m11 = s1_d;
    end
  end

  always_ff @(posedge clk) begin
    mat <= mat_next;
  end

endmodule

// ===== rtl/hc_pair_mult.sv =====
// ----------------------------------------------------------------------------
// hc_pair_mult
// Multiplies one letter pair by the active 2x2 matrix mod 26.
// ----------------------------------------------------------------------------
module hc_pair_mult import hc_pkg::*; (
  input  key_mat_t            mat,
  input  logic [LETTER_W-1:0] p0,
  input  logic [LETTER_W-1:0] p1,
  output logic [LETTER_W-1:0] r0,
  output logic [LETTER_W-1:0] r1
);

  logic [LETTER_W-1:0] q0, q1;
  logic [10:0]         sum0, sum1;

  always_comb begin
    q0   = red26(p0);
    q1   = red26(p1);
    sum0 = 11'(10'(mat.m00) * 10'(q0)) + 11'(10'(mat.m01) * 10'(q1));
    sum1 = 11'(10'(mat.m10) * 10'(q0)) + 11'(10'(mat.m11) * 10'(q1));
    r0   = mod26(sum0);
    r1   = mod26(sum1);
  end

endmodule

// ===== rtl/hill_cipher_2x2_mod26.sv =====
// ----------------------------------------------------------------------------
// hill_cipher_2x2_mod26
// 2x2 hill cipher over letters 0..25: pairs letters, multiplies each pair by
// the key (encrypt) or its inverse mod 26 (decrypt), emits two letters.
// ----------------------------------------------------------------------------
//
//  channel   direction  tdata           tlast        tuser
//  s_axis    in         letter [4:0]    last         -
//  m_axis    out        letter_out[4:0] message_end  {key_error, pair_last}
//  cfg       in         write only: cfg_we, cfg_addr (register index), cfg_wdata
//
//  one letter request is taken per cycle unless the input is held off; a pair
//  leaves as two results, first letter then second, so the output beat rate
//  sets the peak rate; a completed pair is registered in the pair register,
//  multiplied combinationally from it and moved into the output buffer, which
//  offers its first letter; rst is synchronous; after reset or any config
//  write the input is held off while the two-stage matrix pipeline refills
//  a stalled output keeps one pair waiting in the pair register, then the
//  input stalls as well
//
module hill_cipher_2x2_mod26 import hc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  // input letters
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [7:0]            s_axis_tdata,   // [4:0] letter, [7:5] zero
  input  logic                  s_axis_tlast,   // last
  // output letters
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [7:0]            m_axis_tdata,   // [4:0] letter_out, [7:5] zero
  output logic                  m_axis_tlast,   // message_end
  output logic [1:0]            m_axis_tuser,   // [0] pair_last, [1] key_error
  // configuration writes
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [LETTER_W-1:0]   cfg_wdata
);

  // key pipeline
  key_mat_t mat;
  logic     settle;

  hc_key_unit u_key (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .mat       (mat),
    .settle    (settle)
  );

  // pairing state
  logic [LETTER_W-1:0] held_letter;
  logic                have_held;

  // completed pair register
  logic                pv;
  logic [LETTER_W-1:0] p0, p1;
  logic                pend;

  // output buffer: one computed pair, beat selects which letter is shown
  logic                ov;
  logic                obeat;
  logic [LETTER_W-1:0] o0, o1;
  logic                oend;
  logic                oerr;

  logic                out_free, pair_move, acc, forms_pair;
  logic [LETTER_W-1:0] in_letter;
  logic [LETTER_W-1:0] r0, r1;

  assign in_letter  = s_axis_tdata[LETTER_W-1:0];

  // output buffer frees when its second letter goes out
  assign out_free   = !ov || (obeat && m_axis_tready);
  assign pair_move  = pv && out_free;
  assign s_axis_tready = !rst && !settle && (!pv || out_free);
  assign acc        = s_axis_tvalid && s_axis_tready;
  // second letter of a pair, or a lone last letter padded with X
  assign forms_pair = acc && (have_held || s_axis_tlast);

  always_ff @(posedge clk) begin
    if (rst) begin
      have_held <= 1'b0;
    end else if (acc) begin
      have_held <= !have_held && !s_axis_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (acc && !have_held) begin
      held_letter <= in_letter;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pv <= 1'b0;
    end else if (forms_pair) begin
      pv <= 1'b1;
    end else if (pair_move) begin
      pv <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (forms_pair) begin
      p0   <= have_held ? held_letter : in_letter;
      p1   <= have_held ? in_letter : PAD_LETTER;
      pend <= s_axis_tlast;
    end
  end

  hc_pair_mult u_mult (
    .mat (mat),
    .p0  (p0),
    .p1  (p1),
    .r0  (r0),
    .r1  (r1)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      ov    <= 1'b0;
      obeat <= 1'b0;
    end else if (pair_move) begin
      ov    <= 1'b1;
      obeat <= 1'b0;
    end else if (ov && m_axis_tready) begin
      if (obeat) begin
        ov    <= 1'b0;
        obeat <= 1'b0;
      end else begin
        obeat <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pair_move) begin
      o0   <= r0;
      o1   <= r1;
      oend <= pend;
      oerr <= mat.key_error;
    end
  end

  assign m_axis_tvalid = ov;
  assign m_axis_tdata  = {3'b000, obeat ? o1 : o0};
  assign m_axis_tlast  = obeat && oend;
  assign m_axis_tuser  = {oerr, obeat};

  // first letter of a pair is always followed by its second letter
  a_pair_order: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tready && !m_axis_tuser[0])
      |=> (m_axis_tvalid && m_axis_tuser[0]))
    else $error("second letter of pair not presented after first");

  // no input request right after a key change
  a_cfg_settle: assert property (@(posedge clk) disable iff (rst)
    cfg_we |=> !s_axis_tready)
    else $error("input accepted while matrix pipeline refills");

  // an invalid key forces letter zero
  a_key_error_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser[1]) |-> (m_axis_tdata[LETTER_W-1:0] == '0))
    else $error("key error with nonzero letter");

  // completing a pair releases the held letter and fills the pair register
  a_pair_release: assert property (@(posedge clk) disable iff (rst)
    (acc && have_held) |=> (!have_held && pv))
    else $error("pair completion did not release held letter");

endmodule

// ===== bench/hill_cipher_2x2_mod26_checker.sv =====
// ----------------------------------------------------------------------------
// hill_cipher_2x2_mod26_checker
// Watches the letter streams and config writes, works out the cipher letters
// each letter request should produce and compares them with what comes out.
// ----------------------------------------------------------------------------
module hill_cipher_2x2_mod26_checker import hc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  input  logic                  s_axis_tready,
  input  logic [7:0]            s_axis_tdata,   // [4:0] letter
  input  logic                  s_axis_tlast,   // last
  input  logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  input  logic [7:0]            m_axis_tdata,   // [4:0] letter_out
  input  logic                  m_axis_tlast,   // message_end
  input  logic [1:0]            m_axis_tuser,   // [0] pair_last, [1] key_error
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [LETTER_W-1:0]   cfg_wdata,
  output int                    mismatches,
  output int                    pending,
  output int                    letters_checked,
  output int                    key_errors
);

  localparam int unsigned ALPHABET = 26;

  typedef struct packed {
    logic [LETTER_W-1:0] letter_out;
    logic                pair_last;
    logic                message_end;
    logic                key_error;
  } cipher_letter_t;

  cipher_letter_t      cipher_letters_q[$];
  logic [LETTER_W-1:0] key_a, key_b, key_c, key_d;
  logic                decrypt;
  logic [LETTER_W-1:0] held_letter;
  logic                have_held;
  int                  fail_total, checked_total, error_total;

  // append one expected letter at the tail of the queue
  function automatic void queue_cipher_letter(input cipher_letter_t item);
    cipher_letters_q = {cipher_letters_q, item};
  endfunction

  // multiply one pair by the key or its inverse and queue both letters
  function automatic void hill_multiply_pair(input logic [LETTER_W-1:0] first,
                                             input logic [LETTER_W-1:0] second,
                                             input logic closes);
    int unsigned    ka, kb, kc, kd, det, inv, x;
    int unsigned    m00, m01, m10, m11, p0, p1;
    cipher_letter_t lo, hi;
    ka = key_a % ALPHABET;
    kb = key_b % ALPHABET;
    kc = key_c % ALPHABET;
    kd = key_d % ALPHABET;
    det = (ka * kd + ALPHABET * ALPHABET - kb * kc) % ALPHABET;
    inv = 0;
    for (x = 1; x < ALPHABET; x++) begin
      if (inv == 0 && (det * x) % ALPHABET == 1) begin
        inv = x;
      end
    end
    m00 = ka; m01 = kb; m10 = kc; m11 = kd;
    if (decrypt) begin
      m00 = (kd * inv) % ALPHABET;
      m01 = ((ALPHABET - kb) * inv) % ALPHABET;
      m10 = ((ALPHABET - kc) * inv) % ALPHABET;
      m11 = (ka * inv) % ALPHABET;
    end
    p0 = first % ALPHABET;
    p1 = second % ALPHABET;
    lo.letter_out  = (inv == 0) ? '0 : LETTER_W'((m00 * p0 + m01 * p1) % ALPHABET);
    lo.pair_last   = 1'b0;
    lo.message_end = 1'b0;
    lo.key_error   = (inv == 0);
    hi.letter_out  = (inv == 0) ? '0 : LETTER_W'((m10 * p0 + m11 * p1) % ALPHABET);
    hi.pair_last   = 1'b1;
    hi.message_end = closes;
    hi.key_error   = (inv == 0);
    queue_cipher_letter(lo);
    queue_cipher_letter(hi);
  endfunction

  always @(posedge clk) begin
    cipher_letter_t got, want;
    if (rst) begin
      key_a       = 5'd1;
      key_b       = 5'd0;
      key_c       = 5'd0;
      key_d       = 5'd1;
      decrypt     = 1'b0;
      held_letter = '0;
      have_held   = 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        if (have_held) begin
          hill_multiply_pair(held_letter, s_axis_tdata[LETTER_W-1:0], s_axis_tlast);
          have_held = 1'b0;
        end else if (s_axis_tlast) begin
          hill_multiply_pair(s_axis_tdata[LETTER_W-1:0], PAD_LETTER, 1'b1);
        end else begin
          held_letter = s_axis_tdata[LETTER_W-1:0];
          have_held   = 1'b1;
        end
      end

      if (m_axis_tvalid && m_axis_tready) begin
        got.letter_out  = m_axis_tdata[LETTER_W-1:0];
        got.pair_last   = m_axis_tuser[0];
        got.message_end = m_axis_tlast;
        got.key_error   = m_axis_tuser[1];
        if (cipher_letters_q.size() == 0) begin
          $error("cipher letter %0d arrived with no pair pending", got.letter_out);
          fail_total++;
        end else begin
          want = cipher_letters_q.pop_front();
          checked_total++;
          if (want.key_error) error_total++;
          if (got.letter_out !== want.letter_out) begin
            $error("letter_out: expected %0d, got %0d", want.letter_out, got.letter_out);
            fail_total++;
          end
          if (got.pair_last !== want.pair_last) begin
            $error("pair_last: expected %0d, got %0d", want.pair_last, got.pair_last);
            fail_total++;
          end
          if (got.message_end !== want.message_end) begin
            $error("message_end: expected %0d, got %0d", want.message_end, got.message_end);
            fail_total++;
          end
          if (got.key_error !== want.key_error) begin
            $error("key_error: expected %0d, got %0d", want.key_error, got.key_error);
            fail_total++;
          end
        end
      end

      if (cfg_we) begin
        case (cfg_addr)
          REG_KEY_A: key_a = cfg_wdata;
          REG_KEY_B: key_b = cfg_wdata;
          REG_KEY_C: key_c = cfg_wdata;
          REG_KEY_D: key_d = cfg_wdata;
          REG_MODE:  decrypt = cfg_wdata[0];
          default: ;
        endcase
      end
    end
    mismatches      <= fail_total;
    pending         <= cipher_letters_q.size();
    letters_checked <= checked_total;
    key_errors      <= error_total;
  end

endmodule

// ===== bench/hill_cipher_2x2_mod26_tb.sv =====
// ----------------------------------------------------------------------------
// hill_cipher_2x2_mod26_tb
// Drives letter messages through the 2x2 hill cipher under many keys in both
// modes, with random idling on both streams; the checker grades the output.
// ----------------------------------------------------------------------------
module hill_cipher_2x2_mod26_tb import hc_pkg::*;;

  localparam int LETTER_COUNT = 1100;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [7:0]            s_axis_tdata = '0;   // [4:0] letter, [7:5] zero
  logic                  s_axis_tlast = 1'b0; // last
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [7:0]            m_axis_tdata;        // [4:0] letter_out, [7:5] zero
  logic                  m_axis_tlast;        // message_end
  logic [1:0]            m_axis_tuser;        // [0] pair_last, [1] key_error
  logic                  cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [LETTER_W-1:0]   cfg_wdata = '0;

  int mismatches, pending, letters_checked, key_errors;

  // stimulus bookkeeping
  int letters_sent   = 0;
  int key_settings   = 0;
  int held_over_cfg  = 0;
  bit tx_steady      = 1'b0;  // sender runs back to back when set
  bit rx_steady      = 1'b0;  // receiver starts no new stalls when set
  int rx_stall_left  = 0;

  hill_cipher_2x2_mod26 DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we        (cfg_we),
    .cfg_addr      (cfg_addr),
    .cfg_wdata     (cfg_wdata)
  );

  hill_cipher_2x2_mod26_checker u_checker (
    .clk             (clk),
    .rst             (rst),
    .s_axis_tvalid   (s_axis_tvalid),
    .s_axis_tready   (s_axis_tready),
    .s_axis_tdata    (s_axis_tdata),
    .s_axis_tlast    (s_axis_tlast),
    .m_axis_tvalid   (m_axis_tvalid),
    .m_axis_tready   (m_axis_tready),
    .m_axis_tdata    (m_axis_tdata),
    .m_axis_tlast    (m_axis_tlast),
    .m_axis_tuser    (m_axis_tuser),
    .cfg_we          (cfg_we),
    .cfg_addr        (cfg_addr),
    .cfg_wdata       (cfg_wdata),
    .mismatches      (mismatches),
    .pending         (pending),
    .letters_checked (letters_checked),
    .key_errors      (key_errors)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // hard stop well beyond the slowest legal run
  initial begin
    #20_000_000;
    $display("hill_cipher_2x2_mod26 test failed");
    $finish;
  end

  // idle length: mostly none or short, now and then a long one
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  // key value with the corners over-represented, 26..31 included
  function automatic logic [LETTER_W-1:0] pick_key_value();
    int r;
    r = $urandom_range(0, 9);
    case (r)
      0:       return 5'd0;
      1:       return 5'd25;
      2:       return 5'd31;
      3:       return LETTER_W'($urandom_range(26, 31));
      default: return LETTER_W'($urandom_range(0, 31));
    endcase
  endfunction

  // output side: random backpressure, with steady stretches
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (rx_stall_left > 0) begin
      m_axis_tready <= 1'b0;
      rx_stall_left <= rx_stall_left - 1;
    end else if (!rx_steady && $urandom_range(0, 3) == 0) begin
      m_axis_tready <= 1'b0;
      rx_stall_left <= idle_len();
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // one letter request; returns at the edge where it was taken, valid left high
  task automatic send_letter(input logic [LETTER_W-1:0] letter, input logic last);
    int gap;
    gap = tx_steady ? 0 : idle_len();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {3'b000, letter};
    s_axis_tlast  <= last;
    do @(posedge clk); while (!s_axis_tready);
    letters_sent++;
  endtask

  // stop sending and let every outstanding cipher letter drain out
  task automatic drain_letters();
    s_axis_tvalid <= 1'b0;
    repeat (2) @(posedge clk);
    while (pending != 0) @(posedge clk);
    // a held letter leaves nothing pending; give the pipeline time to settle
    repeat (4) @(posedge clk);
  endtask

  // write all five registers on consecutive edges while the block is idle
  task automatic load_key(input logic [LETTER_W-1:0] a, input logic [LETTER_W-1:0] b,
                          input logic [LETTER_W-1:0] c, input logic [LETTER_W-1:0] d,
                          input logic dec);
    drain_letters();
    cfg_we    <= 1'b1;
    cfg_addr  <= REG_KEY_A;
    cfg_wdata <= a;
    @(posedge clk);
    cfg_addr  <= REG_KEY_B;
    cfg_wdata <= b;
    @(posedge clk);
    cfg_addr  <= REG_KEY_C;
    cfg_wdata <= c;
    @(posedge clk);
    cfg_addr  <= REG_KEY_D;
    cfg_wdata <= d;
    @(posedge clk);
    cfg_addr  <= REG_MODE;
    cfg_wdata <= {4'b0000, dec};
    @(posedge clk);
    cfg_we    <= 1'b0;
    key_settings++;
  endtask

  initial begin
    int phase_letters, msg_len, i;
    logic [LETTER_W-1:0] ka, kb, kc, kd;
    logic dec;

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // --- directed part ---
    // reset key is the identity: lone last letter gets the X pad, 31 folds to 5
    send_letter(5'd0, 1'b1);
    send_letter(5'd25, 1'b0);
    send_letter(5'd31, 1'b1);

    // classic invertible key, encrypt then decrypt
    load_key(5'd3, 5'd3, 5'd2, 5'd5, 1'b0);
    send_letter(5'd7, 1'b0);
    send_letter(5'd8, 1'b1);
    send_letter(5'd25, 1'b1);
    load_key(5'd3, 5'd3, 5'd2, 5'd5, 1'b1);
    send_letter(5'd20, 1'b0);
    send_letter(5'd5, 1'b1);
    send_letter(5'd13, 1'b1);

    // negative determinant, still invertible once folded; pair with no end
    load_key(5'd1, 5'd3, 5'd2, 5'd1, 1'b1);
    send_letter(5'd0, 1'b0);
    send_letter(5'd25, 1'b0);
    send_letter(5'd12, 1'b1);

    // zero determinant: key error in both modes
    load_key(5'd2, 5'd4, 5'd1, 5'd2, 1'b0);
    send_letter(5'd3, 1'b0);
    send_letter(5'd4, 1'b1);
    load_key(5'd2, 5'd4, 5'd1, 5'd2, 1'b1);
    send_letter(5'd3, 1'b1);

    // key values above 25, and a mode flip while the first letter is held
    load_key(5'd29, 5'd26, 5'd0, 5'd31, 1'b0);
    send_letter(5'd30, 1'b0);
    load_key(5'd29, 5'd26, 5'd0, 5'd31, 1'b1);
    held_over_cfg++;
    send_letter(5'd1, 1'b1);

    // --- random part: one key setting per phase, random messages in it ---
    while (letters_sent < LETTER_COUNT) begin
      if (key_settings == 7) begin
        ka = 5'd0; kb = 5'd0; kc = 5'd0; kd = 5'd0; dec = 1'b0;
      end else if (key_settings == 8) begin
        ka = 5'd31; kb = 5'd31; kc = 5'd31; kd = 5'd31; dec = 1'b1;
      end else if (key_settings == 9) begin
        ka = 5'd25; kb = 5'd25; kc = 5'd0; kd = 5'd25; dec = 1'b1;
      end else begin
        ka = pick_key_value();
        kb = pick_key_value();
        kc = pick_key_value();
        kd = pick_key_value();
        dec = 1'($urandom_range(0, 1));
      end
      load_key(ka, kb, kc, kd, dec);

      phase_letters = $urandom_range(50, 130);
      while (phase_letters > 0) begin
        tx_steady = ($urandom_range(0, 4) == 0);
        rx_steady = ($urandom_range(0, 4) == 0);
        msg_len = ($urandom_range(0, 5) == 0) ? 1 : $urandom_range(2, 14);
        for (i = 0; i < msg_len; i++) begin
          send_letter(LETTER_W'($urandom_range(0, 31)), i == msg_len - 1);
        end
        phase_letters -= msg_len;
        // sometimes hold off until everything has come out
        if ($urandom_range(0, 15) == 0) begin
          drain_letters();
        end
      end

      // leave a first letter held so the next key setting completes the pair
      if ($urandom_range(0, 9) < 3) begin
        send_letter(LETTER_W'($urandom_range(0, 31)), 1'b0);
        held_over_cfg++;
      end
    end

    // close any held letter, then let the output drain
    send_letter(LETTER_W'($urandom_range(0, 31)), 1'b1);
    drain_letters();
    repeat (10) @(posedge clk);

    $display("sent %0d letters under %0d key settings, %0d held across a key change",
             letters_sent, key_settings, held_over_cfg);
    $display("checked %0d cipher letters, %0d of them flagged with key error",
             letters_checked, key_errors);
    if (mismatches == 0 && pending == 0) begin
      $display("hill_cipher_2x2_mod26 test passed");
    end else begin
      $display("hill_cipher_2x2_mod26 test failed");
    end
    $finish;
  end

endmodule
